// ----- rtl/core/ctok_pkg.sv -----
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, character codes and the operator lookup for the character
// stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctok_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH           = 4;

   // Character codes
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_AMP       = 8'h26;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_UNDERLINE = 8'h5F;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
   localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
   localparam logic [7:0] CH_UPPER_LO  = 8'h41;
   localparam logic [7:0] CH_UPPER_HI  = 8'h5A;
   localparam logic [7:0] CH_LOWER_LO  = 8'h61;
   localparam logic [7:0] CH_LOWER_HI  = 8'h7A;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef enum logic [3:0] {
      KIND_INTEGER    = 4'd0,
      KIND_WORD       = 4'd1,
      KIND_PLUS       = 4'd2,
      KIND_MINUS      = 4'd3,
      KIND_DIVIDE     = 4'd4,
      KIND_MULTIPLY   = 4'd5,
      KIND_LPAREN     = 4'd6,
      KIND_RPAREN     = 4'd7,
      KIND_LBRACE     = 4'd8,
      KIND_RBRACE     = 4'd9,
      KIND_AND        = 4'd10,
      KIND_SEMICOLON  = 4'd11,
      KIND_ASSIGN     = 4'd12,
      KIND_UNDERSCORE = 4'd13,
      KIND_UNHANDLED  = 4'd14
   } token_kind_type;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_INT  = 2'd1,
      RUN_WORD = 2'd2
   } run_kind_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [15:0]    end_position;
      logic [15:0]    token_length;
      logic [7:0]     raw_byte;
   } result_type;

   // Up to two results caused by one input byte
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } packet_type;

   typedef struct packed {
      result_type res;
      logic       last;
   } rsp_item_type;

   function automatic token_kind_type op_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         CH_PLUS:      k = KIND_PLUS;
         CH_MINUS:     k = KIND_MINUS;
         CH_SLASH:     k = KIND_DIVIDE;
         CH_STAR:      k = KIND_MULTIPLY;
         CH_LPAREN:    k = KIND_LPAREN;
         CH_RPAREN:    k = KIND_RPAREN;
         CH_LBRACE:    k = KIND_LBRACE;
         CH_RBRACE:    k = KIND_RBRACE;
         CH_AMP:       k = KIND_AND;
         CH_SEMI:      k = KIND_SEMICOLON;
         CH_EQUAL:     k = KIND_ASSIGN;
         CH_UNDERLINE: k = KIND_UNDERSCORE;
         default:      k = KIND_UNHANDLED;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ctok_if.sv -----
// ----------------------------------------------------------------------------
// ctok_if
// Valid/ready channels of the tokenizer: byte requests and token responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ctok_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] end_position;
   logic [15:0] token_length;
   logic [7:0]  raw_byte;
   logic        last_result;

   modport source (output valid, output token_kind, output end_position,
                   output token_length, output raw_byte, output last_result,
                   input ready);
   modport sink   (input valid, input token_kind, input end_position,
                   input token_length, input raw_byte, input last_result,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ctok_front.sv -----
// ----------------------------------------------------------------------------
// ctok_front
// Classifies each byte, tracks the open run and the byte position, and
// builds a packet of up to two results for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ctok_front #(
   parameter int POSITION_BITS = ctok_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_fire,
   input  wire logic [7:0]         char_code,
   input  wire logic               end_of_text,
   output ctok_pkg::packet_type    push_packet,
   output logic                    push_valid
);
   import ctok_pkg::*;

   run_kind_type             run_ff, run_in;
   logic [15:0]              len_ff, len_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_plus;
   run_kind_type             new_run;
   logic                     emit_char;
   result_type               flush_res, char_res;

   function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
      logic [POSITION_BITS+15:0] ext;
      ext = {16'b0, p};
      return ext[15:0];
   endfunction

   assign pos_plus = POSITION_BITS'(pos_ff + 1'b1);

   always_comb begin
      if (char_code inside {[CH_DIGIT_LO:CH_DIGIT_HI]}) begin
         new_run = RUN_INT;
      end else if (char_code inside {[CH_UPPER_LO:CH_UPPER_HI], [CH_LOWER_LO:CH_LOWER_HI]}) begin
         new_run = RUN_WORD;
      end else begin
         new_run = RUN_NONE;
      end
   end

   always_comb begin
      flush_res.token_kind   = (run_ff == RUN_INT) ? KIND_INTEGER : KIND_WORD;
      flush_res.end_position = pos16(pos_ff);
      flush_res.token_length = len_ff;
      flush_res.raw_byte     = 8'd0;
      char_res.token_kind    = op_kind(char_code);
      char_res.end_position  = pos16(pos_plus);
      char_res.token_length  = 16'd1;
      char_res.raw_byte      = char_code;
   end

   always_comb begin
      run_in             = run_ff;
      len_in             = len_ff;
      pos_in             = pos_ff;
      push_valid         = 1'b0;
      emit_char          = (new_run == RUN_NONE) && (char_code != CH_NEWLINE);
      push_packet.first  = flush_res;
      push_packet.second = char_res;
      push_packet.two    = 1'b0;
      if (req_fire) begin
         if (end_of_text) begin
            // flush any open run and restart the text at index zero
            push_valid = (run_ff != RUN_NONE);
            run_in     = RUN_NONE;
            len_in     = 16'd0;
            pos_in     = '0;
         end else begin
            pos_in = pos_plus;
            if ((run_ff != RUN_NONE) && (run_ff == new_run)) begin
               len_in = (len_ff == LEN_MAX) ? len_ff : 16'(len_ff + 16'd1);
            end else begin
               run_in = new_run;
               len_in = (new_run != RUN_NONE) ? 16'd1 : 16'd0;
               if (run_ff != RUN_NONE) begin
                  push_valid      = 1'b1;
                  push_packet.two = emit_char;
               end else begin
                  push_packet.first = char_res;
                  push_valid        = emit_char;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= RUN_NONE;
         len_ff <= 16'd0;
         pos_ff <= '0;
      end else begin
         run_ff <= run_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ctok_queue.sv -----
// ----------------------------------------------------------------------------
// ctok_queue
// Small FIFO of result packets between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ctok_queue #(
   parameter int DEPTH = ctok_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ctok_pkg::packet_type push_packet,
   output logic                      push_ready,
   input  wire logic                 pop,
   output ctok_pkg::packet_type      head_packet,
   output logic                      head_valid
);
   import ctok_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   packet_type            slots_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_packet = slots_ff[rd_ptr_ff];
   assign do_push     = push && push_ready;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_BITS'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ctok_back.sv -----
// ----------------------------------------------------------------------------
// ctok_back
// Drains packets one result at a time into the registered response stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ctok_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctok_pkg::packet_type head_packet,
   input  wire logic                 head_valid,
   output logic                      pop,
   output ctok_pkg::rsp_item_type    rsp_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready
);
   import ctok_pkg::*;

   rsp_item_type item_ff, item_in;
   logic         valid_ff, valid_in;
   logic         second_ff, second_in;
   logic         load;

   assign load      = !valid_ff || rsp_ready;
   assign rsp_item  = item_ff;
   assign rsp_valid = valid_ff;

   always_comb begin
      item_in   = item_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (second_ff) begin
               item_in.res  = head_packet.second;
               item_in.last = 1'b1;
               pop          = 1'b1;
               second_in    = 1'b0;
            end else begin
               item_in.res  = head_packet.first;
               item_in.last = !head_packet.two;
               pop          = !head_packet.two;
               second_in    = head_packet.two;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/character_stream_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// character_stream_tokenizer_top
// Byte-at-a-time tokenizer: integer and word runs, single-character
// operators, unhandled bytes, end-of-text flush.
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                                        handshake
//   ---------  ----  ---------------------------------------------  ---------
//   req_chan   in    char_code[7:0], end_of_text                    valid/ready
//   rsp_chan   out   token_kind[3:0], end_position[15:0],           valid/ready
//                    token_length[15:0], raw_byte[7:0], last_result
//
// One byte is accepted per cycle. The front end updates the run and position
// state in the accept cycle and queues a packet of up to two results; the
// back end drains one result per cycle into the output register while
// rsp_chan.ready allows, and the four-packet queue absorbs the extra result
// of a byte that causes two. A response passes the queue, then the output
// register. req_chan.ready drops only while the queue is full.
// Synchronous reset clears run, length, position, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module character_stream_tokenizer_top #(
   parameter int POSITION_BITS = ctok_pkg::POSITION_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   ctok_req_if.sink   req_chan,
   ctok_rsp_if.source rsp_chan
);
   import ctok_pkg::*;

   packet_type   push_packet;
   packet_type   head_packet;
   logic         push_valid;
   logic         push_ready;
   logic         head_valid;
   logic         pop;
   logic         req_fire;
   rsp_item_type rsp_item;

   // accept a byte whenever the queue has room
   assign req_chan.ready = push_ready;
   assign req_fire       = req_chan.valid && push_ready;

   ctok_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .char_code   (req_chan.char_code),
      .end_of_text (req_chan.end_of_text),
      .push_packet (push_packet),
      .push_valid  (push_valid)
   );

   ctok_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push_valid),
      .push_packet (push_packet),
      .push_ready  (push_ready),
      .pop         (pop),
      .head_packet (head_packet),
      .head_valid  (head_valid)
   );

   ctok_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_packet (head_packet),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_item    (rsp_item),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready)
   );

   // drive the response payload from the output register
   assign rsp_chan.token_kind   = rsp_item.res.token_kind;
   assign rsp_chan.end_position = rsp_item.res.end_position;
   assign rsp_chan.token_length = rsp_item.res.token_length;
   assign rsp_chan.raw_byte     = rsp_item.res.raw_byte;
   assign rsp_chan.last_result  = rsp_item.last;

endmodule

`default_nettype wire
